// ===== rtl/rpnh_pkg.sv =====
`timescale 1ns / 1ps
package rpnh_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int ANGLE_BITS   = 12;
   localparam int VIDX_W       = $clog2(MAX_VERTICES);
   localparam int QUARTER      = 1 << (ANGLE_BITS - 2);
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARALLEL_EPS = 2'd1;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1 << 30;

   typedef struct packed {
      logic               kind;
      logic [5:0]         vertex_index;
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic [11:0]        angle_code;
   } req_type;

   typedef struct packed {
      logic [31:0] distance;
      logic        hit;
   } rsp_type;

   typedef logic [QUARTER-1:0][14:0] rom_type;

   function automatic logic [14:0] round_q14(input longint v);
      longint c;
      c = v;
      if (c < 0) c = 0;
      if (c > longint'(ONE_Q30)) c = longint'(ONE_Q30);
      c = (c + 32768) >>> 16;
      return c[14:0];
   endfunction

   function automatic rom_type gen_rom(input bit want_cos);
      rom_type         rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          s_acc;
      longint          c_acc;
      for (int r = 0; r < QUARTER; r++) begin
         x = (longint'(r) * PI_HALF_Q30) >> (ANGLE_BITS - 2);
         x2 = (x * x) >> 30;
         s_acc = longint'(x);
         term = x;
         term = ((term * x2) >> 30) / 64'd6;   s_acc = s_acc - longint'(term);
         term = ((term * x2) >> 30) / 64'd20;  s_acc = s_acc + longint'(term);
         term = ((term * x2) >> 30) / 64'd42;  s_acc = s_acc - longint'(term);
         term = ((term * x2) >> 30) / 64'd72;  s_acc = s_acc + longint'(term);
         term = ((term * x2) >> 30) / 64'd110; s_acc = s_acc - longint'(term);
         term = ((term * x2) >> 30) / 64'd156; s_acc = s_acc + longint'(term);
         c_acc = longint'(ONE_Q30);
         term = ONE_Q30;
         term = ((term * x2) >> 30) / 64'd2;   c_acc = c_acc - longint'(term);
         term = ((term * x2) >> 30) / 64'd12;  c_acc = c_acc + longint'(term);
         term = ((term * x2) >> 30) / 64'd30;  c_acc = c_acc - longint'(term);
         term = ((term * x2) >> 30) / 64'd56;  c_acc = c_acc + longint'(term);
         term = ((term * x2) >> 30) / 64'd90;  c_acc = c_acc - longint'(term);
         term = ((term * x2) >> 30) / 64'd132; c_acc = c_acc + longint'(term);
         term = ((term * x2) >> 30) / 64'd182; c_acc = c_acc - longint'(term);
         rom[r] = want_cos ? round_q14(c_acc) : round_q14(s_acc);
      end
      return rom;
   endfunction

endpackage

// ===== rtl/rpnh_div.sv =====
`timescale 1ns / 1ps
module rpnh_div import rpnh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [66:0] num,
   input  logic [48:0] den,
   output logic        done,
   output logic [31:0] quot
);

   logic [48:0] rem_ff, rem_in;
   logic [31:0] low_ff, low_in;
   logic [31:0] q_ff, q_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [49:0] trial;
   logic [48:0] den_ff;

   assign trial = {rem_ff, low_ff[31]};

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         if (num >= {den, 18'd0}) begin
            q_in    = '1;
            done_in = 1'b1;
         end else begin
            rem_in = num[66:18];
            low_in = {num[17:0], 14'd0};
            q_in   = '0;
            cnt_in = '1;
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         low_in = {low_ff[30:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 49'(trial - {1'b0, den_ff});
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[48:0];
            q_in   = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (start) den_ff <= den;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== rtl/ray_polygon_nearest_hit.sv =====
`timescale 1ns / 1ps
// channel   dir   handshake              payload
// req       in    req_valid/req_ready    req_data (rpnh_pkg::req_type)
// rsp       out   rsp_valid/rsp_ready    rsp_data (rpnh_pkg::rsp_type)
// csr       in    csr_we                 csr_index, csr_wdata
// A load writes vertex storage and leaves the block idle. A query holds req_ready low
// until its result is taken into the rsp register, while it walks the edges one by one;
// one shared 33x33 multiplier runs six products per edge and a bit-serial divider runs
// 32 steps for each edge that passes the hit test, unless the quotient saturates.
// Reset is synchronous and active high; vertex storage is not cleared.
// A finished result waits in the rsp register; a load or a new query is taken
// while it waits, and a query that ends before it is taken holds.
module ray_polygon_nearest_hit import rpnh_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROM, ST_DIR, ST_FETCH, ST_EDGE, ST_M0, ST_M1, ST_M2, ST_M3,
      ST_M4, ST_M5, ST_M6, ST_TEST, ST_DIV, ST_NEXT, ST_DONE
   } state_type;

   localparam rom_type SIN_ROM = gen_rom(1'b0);
   localparam rom_type COS_ROM = gen_rom(1'b1);

   logic signed [31:0] mem_x [MAX_VERTICES];
   logic signed [31:0] mem_y [MAX_VERTICES];

   state_type          state_ff;
   logic [6:0]         count_ff;
   logic [15:0]        eps_ff;
   logic [6:0]         n_ff, i_ff;
   logic signed [31:0] ox_ff, oy_ff;
   logic [11:0]        angle_ff;
   logic [14:0]        sin_q_ff, cos_q_ff;
   logic signed [31:0] mx_q_ff, my_q_ff;
   logic signed [31:0] p0x_ff, p0y_ff, p1x_ff, p1y_ff;
   logic signed [15:0] dx_ff, dy_ff;
   logic signed [32:0] v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic signed [65:0] prod_ff, acc_ff;
   logic signed [49:0] det_ff, un_ff;
   logic signed [66:0] tn_ff;
   logic [31:0]        best_ff;
   logic               hit_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [VIDX_W-1:0]  rd_addr;
   logic [ANGLE_BITS-3:0] rom_idx;
   logic [6:0]         i_next;
   logic               last;
   logic signed [31:0] p2x, p2y;
   logic signed [32:0] mul_a, mul_b, dx33, dy33;
   logic signed [65:0] diff66;
   logic signed [66:0] diff67;
   logic [49:0]        adet_full;
   logic [66:0]        atn;
   logic               skip;
   logic               div_start, div_done;
   logic [31:0]        div_q;
   logic               accept;
   logic [6:0]         n_clip;

   assign accept  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign i_next  = i_ff + 7'd1;
   assign last    = (i_next == n_ff);
   assign rd_addr = (state_ff == ST_FETCH) ? i_next[VIDX_W-1:0] : '0;
   assign rom_idx = angle_ff[ANGLE_BITS-3:0];
   assign p2x     = last ? p0x_ff : mx_q_ff;
   assign p2y     = last ? p0y_ff : my_q_ff;
   assign dx33    = {{17{dx_ff[15]}}, dx_ff};
   assign dy33    = {{17{dy_ff[15]}}, dy_ff};
   assign diff66  = acc_ff - prod_ff;
   assign diff67  = {acc_ff[65], acc_ff} - {prod_ff[65], prod_ff};
   assign adet_full = det_ff[49] ? 50'(-det_ff) : det_ff;
   assign atn     = tn_ff[66] ? 67'(-tn_ff) : tn_ff;
   assign n_clip  = (count_ff > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : count_ff;

   always_comb begin
      unique case (state_ff)
         ST_M0:   begin mul_a = v2x_ff; mul_b = dy33;   end
         ST_M1:   begin mul_a = v2y_ff; mul_b = dx33;   end
         ST_M2:   begin mul_a = dx33;   mul_b = v1y_ff; end
         ST_M3:   begin mul_a = dy33;   mul_b = v1x_ff; end
         ST_M4:   begin mul_a = v2x_ff; mul_b = v1y_ff; end
         ST_M5:   begin mul_a = v2y_ff; mul_b = v1x_ff; end
         default: begin mul_a = v2x_ff; mul_b = v1y_ff; end
      endcase
   end

   always_comb begin
      skip = 1'b0;
      if (det_ff == '0) skip = 1'b1;
      if (adet_full[48:0] < {33'd0, eps_ff}) skip = 1'b1;
      if (!det_ff[49]) begin
         if (un_ff < 0 || un_ff > det_ff) skip = 1'b1;
      end else begin
         if (un_ff > 0 || un_ff < det_ff) skip = 1'b1;
      end
      if (tn_ff == '0) skip = 1'b1;
      if (tn_ff[66] != det_ff[49]) skip = 1'b1;
   end

   assign div_start = (state_ff == ST_TEST) && !skip;

   rpnh_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (atn),
      .den   (adet_full[48:0]),
      .done  (div_done),
      .quot  (div_q)
   );

   always_ff @(posedge clock) begin
      if (accept && req_data.kind == KIND_LOAD &&
          {1'b0, req_data.vertex_index} < 7'(MAX_VERTICES)) begin
         mem_x[req_data.vertex_index[VIDX_W-1:0]] <= req_data.vertex_x;
         mem_y[req_data.vertex_index[VIDX_W-1:0]] <= req_data.vertex_y;
      end
      mx_q_ff  <= mem_x[rd_addr];
      my_q_ff  <= mem_y[rd_addr];
      sin_q_ff <= SIN_ROM[rom_idx];
      cos_q_ff <= COS_ROM[rom_idx];
      prod_ff  <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= 7'd3;
         eps_ff       <= 16'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_VERTEX_COUNT) count_ff <= csr_wdata[6:0];
            else if (csr_index == CSR_PARALLEL_EPS) eps_ff <= csr_wdata;
         end
         priority if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready))
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         else rsp_valid_ff <= rsp_valid_ff;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_data.kind == KIND_QUERY) begin
                  ox_ff    <= req_data.origin_x;
                  oy_ff    <= req_data.origin_y;
                  angle_ff <= req_data.angle_code;
                  n_ff     <= n_clip;
                  best_ff  <= '1;
                  hit_ff   <= 1'b0;
                  state_ff <= ST_ROM;
               end
            end
            ST_ROM: state_ff <= ST_DIR;
            ST_DIR: begin
               unique case (angle_ff[ANGLE_BITS-1:ANGLE_BITS-2])
                  2'd0: begin dx_ff <= 16'(cos_q_ff);  dy_ff <= 16'(sin_q_ff);  end
                  2'd1: begin dx_ff <= -16'(sin_q_ff); dy_ff <= 16'(cos_q_ff);  end
                  2'd2: begin dx_ff <= -16'(cos_q_ff); dy_ff <= -16'(sin_q_ff); end
                  default: begin dx_ff <= 16'(sin_q_ff); dy_ff <= -16'(cos_q_ff); end
               endcase
               p0x_ff <= mx_q_ff;
               p0y_ff <= my_q_ff;
               p1x_ff <= mx_q_ff;
               p1y_ff <= my_q_ff;
               i_ff   <= '0;
               state_ff <= (n_ff == '0) ? ST_DONE : ST_FETCH;
            end
            ST_FETCH: state_ff <= ST_EDGE;
            ST_EDGE: begin
               v1x_ff <= {p1x_ff[31], p1x_ff} - {ox_ff[31], ox_ff};
               v1y_ff <= {p1y_ff[31], p1y_ff} - {oy_ff[31], oy_ff};
               v2x_ff <= {p2x[31], p2x} - {p1x_ff[31], p1x_ff};
               v2y_ff <= {p2y[31], p2y} - {p1y_ff[31], p1y_ff};
               p1x_ff <= p2x;
               p1y_ff <= p2y;
               state_ff <= ST_M0;
            end
            ST_M0: state_ff <= ST_M1;
            ST_M1: begin acc_ff <= prod_ff; state_ff <= ST_M2; end
            ST_M2: begin det_ff <= diff66[49:0]; state_ff <= ST_M3; end
            ST_M3: begin acc_ff <= prod_ff; state_ff <= ST_M4; end
            ST_M4: begin un_ff <= diff66[49:0]; state_ff <= ST_M5; end
            ST_M5: begin acc_ff <= prod_ff; state_ff <= ST_M6; end
            ST_M6: begin tn_ff <= diff67; state_ff <= ST_TEST; end
            ST_TEST: state_ff <= skip ? ST_NEXT : ST_DIV;
            ST_DIV: begin
               if (div_done) begin
                  hit_ff <= 1'b1;
                  if (div_q < best_ff) best_ff <= div_q;
                  state_ff <= ST_NEXT;
               end
            end
            ST_NEXT: begin
               if (last) state_ff <= ST_DONE;
               else begin
                  i_ff     <= i_next;
                  state_ff <= ST_FETCH;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.distance  <= best_ff;
                  rsp_ff.hit       <= hit_ff;
                  state_ff         <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |=> state_ff == ST_DIV)
      else $error("divider started outside the edge test");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished while not waited on");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("transaction raised outside the done state");
   a_miss_all_ones: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !hit_ff) |-> best_ff == '1)
      else $error("miss carries a finite distance");

endmodule

// ===== dv/ray_polygon_nearest_hit_tb.sv =====
`timescale 1ns / 1ps
module ray_polygon_nearest_hit_tb;
   import rpnh_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam int IDLE_LIMIT = 40000;
   localparam int SETTLE_CYCLES = 40;
   localparam int REQ_W = $bits(req_type);

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           rkind;
      req_type                item;
      bit                     fixed;
      rsp_type                want;
      logic [CSR_INDEX_W-1:0] cidx;
      logic [15:0]            cval;
   } row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0]            csr_wdata = '0;

   int      idle_pct = 0;
   int      stall_pct = 0;
   int      errors = 0;
   int      quiet_cycles = 0;
   rsp_type hit_queue[$];
   row_type rows[$];

   // predictor state
   int          dir_cos[4096];
   int          dir_sin[4096];
   logic [31:0] pts_x[MAX_VERTICES];
   logic [31:0] pts_y[MAX_VERTICES];
   int          n_verts = 3;
   longint      eps_reg = 1;

   ray_polygon_nearest_hit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   function automatic longint to_q14(longint v);
      if (v < 0) v = 0;
      if (v > longint'(ONE_Q30)) v = longint'(ONE_Q30);
      return (v + 32768) >>> 16;
   endfunction

   function automatic void build_dirs();
      longint unsigned x, x2, term;
      longint          s_acc, c_acc, s, c;
      int              quad, r;
      for (int code = 0; code < 4096; code++) begin
         quad = code >> 10;
         r = code & 1023;
         x = (longint'(r) * PI_HALF_Q30) >> 10;
         x2 = (x * x) >> 30;
         s_acc = longint'(x);
         term = x;
         for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            s_acc = (k & 1) ? s_acc - longint'(term) : s_acc + longint'(term);
         end
         c_acc = longint'(ONE_Q30);
         term = ONE_Q30;
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
            c_acc = (k & 1) ? c_acc - longint'(term) : c_acc + longint'(term);
         end
         s = to_q14(s_acc);
         c = to_q14(c_acc);
         case (quad)
            0: begin dir_cos[code] = int'(c);  dir_sin[code] = int'(s);  end
            1: begin dir_cos[code] = int'(-s); dir_sin[code] = int'(c);  end
            2: begin dir_cos[code] = int'(-c); dir_sin[code] = int'(-s); end
            default: begin dir_cos[code] = int'(s); dir_sin[code] = int'(-c); end
         endcase
      end
   endfunction

   function automatic rsp_type cast_ray(req_type q);
      longint                ox, oy, dx, dy, p1x, p1y, p2x, p2y;
      longint                v1x, v1y, v2x, v2y, det, un, adet;
      logic signed [129:0]   w1x, w1y, w2x, w2y, tn;
      logic [159:0]          num, quo;
      rsp_type               res;
      int                    n, j;
      res.distance = 32'hFFFF_FFFF;
      res.hit = 1'b0;
      ox = longint'(q.origin_x);
      oy = longint'(q.origin_y);
      dx = dir_cos[q.angle_code];
      dy = dir_sin[q.angle_code];
      n = (n_verts > MAX_VERTICES) ? MAX_VERTICES : n_verts;
      for (int i = 0; i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         p1x = longint'($signed(pts_x[i]));
         p1y = longint'($signed(pts_y[i]));
         p2x = longint'($signed(pts_x[j]));
         p2y = longint'($signed(pts_y[j]));
         v1x = p1x - ox;
         v1y = p1y - oy;
         v2x = p2x - p1x;
         v2y = p2y - p1y;
         det = v2x * dy - v2y * dx;
         if (det == 0) continue;
         adet = (det < 0) ? -det : det;
         if (adet < eps_reg) continue;
         un = dx * v1y - dy * v1x;
         if (det > 0 ? (un < 0 || un > det) : (un > 0 || un < det)) continue;
         w1x = v1x;
         w1y = v1y;
         w2x = v2x;
         w2y = v2y;
         tn = w2x * w1y - w2y * w1x;
         if (tn == 0) continue;
         if ((tn < 0) != (det < 0)) continue;
         if (tn < 0) tn = -tn;
         num = 160'(tn) << 14;
         quo = num / 160'(adet);
         res.hit = 1'b1;
         if (quo < 160'(res.distance)) res.distance = quo[31:0];
      end
      return res;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (hit_queue.size() == 0) begin
            report("unexpected transaction", {31'd0, rsp_data.hit}, 32'd0);
         end else begin
            want = hit_queue.pop_front();
            if (rsp_data.hit !== want.hit)
               report("hit", {31'd0, rsp_data.hit}, {31'd0, want.hit});
            if (rsp_data.distance !== want.distance)
               report("distance", rsp_data.distance, want.distance);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("[ray_polygon_nearest_hit] ERROR");
         $finish;
      end
   end

   task automatic send(req_type t, bit fixed, rsp_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_data <= '0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (!req_ready);
      if (t.kind == KIND_LOAD) begin
         pts_x[t.vertex_index] = t.vertex_x;
         pts_y[t.vertex_index] = t.vertex_y;
      end else begin
         hit_queue = {hit_queue, (fixed ? want : cast_ray(t))};
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [15:0] val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_VERTEX_COUNT) n_verts = val & 16'h7F;
      else if (idx == CSR_PARALLEL_EPS) eps_reg = val;
   endtask

   function automatic req_type load_item(int idx, int x, int y);
      req_type t;
      t = req_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
      t.kind = KIND_LOAD;
      t.vertex_index = 6'(idx);
      t.vertex_x = x;
      t.vertex_y = y;
      return t;
   endfunction

   function automatic req_type query_item(int ox, int oy, int ang);
      req_type t;
      t = req_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
      t.kind = KIND_QUERY;
      t.origin_x = ox;
      t.origin_y = oy;
      t.angle_code = 12'(ang);
      return t;
   endfunction

   function automatic void add_load(int idx, int x, int y);
      row_type r;
      r = '{rkind: ROW_ITEM, item: load_item(idx, x, y), fixed: 0, want: '0,
            cidx: '0, cval: '0};
      rows = {rows, r};
   endfunction

   function automatic void add_query(int ox, int oy, int ang, bit fixed, rsp_type want);
      row_type r;
      r = '{rkind: ROW_ITEM, item: query_item(ox, oy, ang), fixed: fixed, want: want,
            cidx: '0, cval: '0};
      rows = {rows, r};
   endfunction

   function automatic void add_csr(logic [CSR_INDEX_W-1:0] idx, logic [15:0] val);
      row_type r;
      r = '{rkind: ROW_CSR, item: '0, fixed: 0, want: '0, cidx: idx, cval: val};
      rows = {rows, r};
   endfunction

   function automatic int small_coord(int span);
      return $signed($urandom_range(2 * span)) - span;
   endfunction

   task automatic random_phase(int items, int count, int eps, int idle, int stall);
      req_type t;
      int      c;
      write_csr(CSR_VERTEX_COUNT, 16'(count) | 16'($urandom_range(511) << 7));
      write_csr(CSR_PARALLEL_EPS, 16'(eps));
      if ($urandom_range(1)) write_csr(CSR_SPARE_2, 16'($urandom));
      else write_csr(CSR_SPARE_3, 16'($urandom));
      idle_pct = idle;
      stall_pct = stall;
      for (int k = 0; k < items; k++) begin
         c = $urandom_range(99);
         if (c < 22)
            t = load_item($urandom_range(63), small_coord(1 << 22), small_coord(1 << 22));
         else if (c < 30)
            t = load_item($urandom_range(63), $urandom, $urandom);
         else if (c < 88)
            t = query_item(small_coord(1 << 21), small_coord(1 << 21), $urandom_range(4095));
         else
            t = query_item($urandom, $urandom, $urandom_range(4095));
         send(t, 0, '0);
      end
   endtask

   initial begin
      rsp_type none;
      none.distance = 32'hFFFF_FFFF;
      none.hit = 1'b0;
      build_dirs();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // triangle around the origin, reset count and epsilon
      add_load(0, -10 << 16, -10 << 16);
      add_load(1, 10 << 16, -10 << 16);
      add_load(2, 0, 10 << 16);
      add_query(0, 0, 0, 0, none);
      add_query(0, 0, 1024, 0, none);
      add_query(0, 0, 2048, 0, none);
      add_query(0, 0, 3072, 0, none);
      add_query(0, 0, 4095, 0, none);
      add_query(0, 0, 512, 0, none);
      add_query(100 << 16, 0, 0, 1, none);
      add_query(32'h8000_0000, 0, 0, 0, none);
      add_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 2560, 0, none);
      // extreme vertices
      add_load(0, 32'h8000_0000, 32'h8000_0000);
      add_load(1, 32'h7FFF_FFFF, 32'h8000_0000);
      add_load(2, 0, 32'h7FFF_FFFF);
      add_query(0, 0, 1024, 0, none);
      add_query(0, 32'h7FFF_FF00, 3072, 0, none);
      // all vertices coincide: zero determinant everywhere
      add_load(0, 5 << 16, 5 << 16);
      add_load(1, 5 << 16, 5 << 16);
      add_load(2, 5 << 16, 5 << 16);
      add_csr(CSR_PARALLEL_EPS, 16'd0);
      add_query(0, 0, 512, 1, none);
      add_csr(CSR_VERTEX_COUNT, 16'd0);
      add_query(0, 0, 0, 1, none);
      add_load(1, 9 << 16, 0);
      add_csr(CSR_VERTEX_COUNT, 16'd2);
      add_query(3 << 16, -4 << 16, 1024, 0, none);
      add_csr(CSR_VERTEX_COUNT, 16'd1);
      add_query(5 << 16, 0, 1024, 0, none);

      foreach (rows[i]) begin
         if (rows[i].rkind == ROW_CSR) write_csr(rows[i].cidx, rows[i].cval);
         else send(rows[i].item, rows[i].fixed, rows[i].want);
      end

      // fill every slot so any count reads written vertices only
      write_csr(CSR_VERTEX_COUNT, 16'd3);
      for (int i = 0; i < MAX_VERTICES; i++)
         send(load_item(i, small_coord(1 << 22), small_coord(1 << 22)), 0, none);

      random_phase(68, 3, 1, 0, 0);
      random_phase(68, 4, 0, 79, 0);
      random_phase(68, 6, 65535, 0, 79);
      random_phase(68, 8, $urandom_range(65535), 37, 37);
      random_phase(40, 64, 1, 0, 0);
      random_phase(30, 127, $urandom_range(255), 37, 37);
      random_phase(68, 5, $urandom_range(4095), 79, 0);
      random_phase(68, 3, $urandom_range(65535), 0, 79);
      random_phase(40, 2, 1, 37, 37);
      random_phase(40, 0, 1, 0, 0);

      drain();
      if (errors == 0) begin
         $display("[ray_polygon_nearest_hit] OK");
      end else begin
         $display("[ray_polygon_nearest_hit] ERROR");
      end
      $finish;
   end

endmodule
